FILE: hdl/iof_pkg.sv
// Package: shared types and constants for the observable-form IIR filter.
`default_nettype none
package iof_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORDER = 3'd0,
    REG_DEN   = 3'd1,
    REG_NUM   = 3'd2,
    REG_FLAGS = 3'd3,
    REG_LOWER = 3'd4,
    REG_UPPER = 3'd5,
    REG_STEP  = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_LIMIT,
    ST_DIV,
    ST_QUANT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       start;
    logic signed [32:0] dividend;
    logic [30:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic signed [33:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: hdl/iof_if.sv
// Interfaces: valid/ready item channels for samples, results and configuration.
`default_nettype none
interface iof_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface iof_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/iof_div.sv
// Floor divider: restoring, one quotient bit per cycle, signed dividend.
`default_nettype none
module iof_div
  import iof_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output      div_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [32:0] mag_r, mag_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [32:0] quo_r, quo_nxt;
  logic [30:0] dvs_r, dvs_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    trial    = {rem_r, mag_r[32]} - {2'b00, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd33;
      neg_nxt  = req.dividend[32];
      // negative: divide (-v - 1) and map to -(q+1), which is floor
      mag_nxt  = req.dividend[32] ? ~req.dividend : req.dividend;
      rem_nxt  = '0;
      quo_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[31:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], mag_r[32]};
        quo_nxt = {quo_r[31:0], 1'b0};
      end
      mag_nxt = {mag_r[31:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? ~{1'b0, quo_r} : {1'b0, quo_r};

endmodule
`default_nettype wire

FILE: hdl/iir_observable_form_filter.sv
// Top level: observable canonical form IIR filter with clamp and quantizer.
//
//   channel | dir | payload
//   in_     | in  | sample_in    s32 Q16.16
//   out_    | out | filtered_out s32 Q16.16
//   cfg_    | in  | index 3b, data 64b
//
// Each item steps the shared multiplier/adder through MUL_A, MUL_B and SUM for
// every state word, then LIMIT and OUT; quantizing (flags bit 2, nonzero step)
// inserts DIV on the divider and the QUANT rebuild between LIMIT and OUT.
// The FSM returns to IDLE after OUT before it takes the next item.
// in_ready is high only in idle; a held result stalls the next item in output.
// The result register holds until taken; rst_n clears the FSM, out valid, the filter state and config (order set to 1).
`default_nettype none
module iir_observable_form_filter
  import iof_pkg::*;
#(
  parameter int unsigned MAX_ORDER = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  iof_sample_if.sink   in_ch,
  iof_sample_if.source out_ch,
  iof_cfg_if.sink      cfg_ch
);

  localparam int unsigned IdxW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  logic [2:0]         order_r;
  logic [63:0]        den_r, num_r;
  logic [2:0]         flags_r;
  logic signed [31:0] lower_r, upper_r;
  logic [30:0]        step_r;

  logic signed [31:0] st_r [MAX_ORDER];
  logic signed [31:0] nx_r [MAX_ORDER];

  state_t state_r, state_nxt;
  logic [IdxW-1:0]    idx_r, idx_nxt;
  logic [IdxW-1:0]    last_w;
  logic signed [31:0] u_r, top_r;
  logic signed [47:0] prod_r;
  logic signed [48:0] acc_r;
  logic signed [31:0] y_r;
  logic               out_valid_r;
  logic signed [31:0] out_data_r;

  logic signed [15:0] coef;
  logic signed [31:0] mop;
  logic signed [47:0] mul;
  logic signed [48:0] sum;
  logic signed [36:0] rnd;
  logic signed [31:0] sat;
  logic signed [66:0] qprod;
  logic signed [67:0] qsum;
  logic signed [31:0] qsat;
  logic signed [31:0] lim;
  logic signed [33:0] quot_r;
  div_req_t dreq;
  div_rsp_t drsp;

  iof_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_comb begin
    if (order_r == 3'd0) last_w = '0;
    else if ({29'd0, order_r} > 32'(MAX_ORDER)) last_w = IdxW'(MAX_ORDER - 1);
    else last_w = IdxW'(order_r - 3'd1);
  end

  always_comb begin
    if (state_r == ST_MUL_A) begin
      coef = den_r[{4'd0, idx_r} * 6'd16 +: 16];
      mop  = top_r;
    end else begin
      coef = num_r[{4'd0, idx_r} * 6'd16 +: 16];
      mop  = u_r;
    end
    mul  = coef * mop;
    sum  = (idx_r == '0) ? 49'sd0 : {{5{st_r[idx_r - 1'b1][31]}}, st_r[idx_r - 1'b1], 12'd0};
    sum  = sum + acc_r + 49'(prod_r) + 49'sd2048;
    rnd  = sum[48:12];
    if (rnd > 37'sd2147483647) sat = 32'sh7fffffff;
    else if (rnd < -37'sd2147483648) sat = 32'sh80000000;
    else sat = rnd[31:0];
  end

  always_comb begin
    lim = nx_r[last_w];
    if (flags_r[0] && lim < lower_r) lim = lower_r;
    else if (flags_r[1] && lim > upper_r) lim = upper_r;
    qprod = quot_r * $signed({2'b00, step_r});
    qsum  = 68'(qprod) + 68'(lower_r);
    if (qsum > 68'sd2147483647) qsat = 32'sh7fffffff;
    else if (qsum < -68'sd2147483648) qsat = 32'sh80000000;
    else qsat = qsum[31:0];
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE:  if (in_ch.valid) begin
        state_nxt = ST_MUL_A;
        idx_nxt   = '0;
      end
      ST_MUL_A: state_nxt = ST_MUL_B;
      ST_MUL_B: state_nxt = ST_SUM;
      ST_SUM:   if (idx_r == last_w) state_nxt = ST_LIMIT;
        else begin
          state_nxt = ST_MUL_A;
          idx_nxt   = idx_r + 1'b1;
        end
      ST_LIMIT: if (flags_r[2] && step_r != '0) state_nxt = ST_DIV;
        else state_nxt = ST_OUT;
      ST_DIV:   if (drsp.done) state_nxt = ST_QUANT;
      ST_QUANT: state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    dreq.start    = (state_r == ST_LIMIT) && flags_r[2] && step_r != '0;
    dreq.dividend = 33'(lim) - 33'(lower_r);
    dreq.divisor  = step_r;
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      order_r     <= 3'd1;
      den_r       <= '0;
      num_r       <= '0;
      flags_r     <= '0;
      lower_r     <= '0;
      upper_r     <= '0;
      step_r      <= '0;
      for (int i = 0; i < MAX_ORDER; i++) st_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_ORDER: order_r <= cfg_ch.data[2:0];
          REG_DEN:   den_r   <= cfg_ch.data;
          REG_NUM:   num_r   <= cfg_ch.data;
          REG_FLAGS: flags_r <= cfg_ch.data[2:0];
          REG_LOWER: lower_r <= cfg_ch.data[31:0];
          REG_UPPER: upper_r <= cfg_ch.data[31:0];
          REG_STEP:  step_r  <= cfg_ch.data[30:0];
          default: ;
        endcase
      end
      if (state_r == ST_LIMIT) begin
        for (int i = 0; i < MAX_ORDER; i++)
          if (IdxW'(i) <= last_w) st_r[i] <= nx_r[i];
      end
      if (state_r == ST_OUT && (!out_valid_r || out_ch.ready)) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
    if (in_ch.valid && state_r == ST_IDLE) begin
      u_r   <= in_ch.data;
      top_r <= st_r[last_w];
    end
    unique case (state_r)
      ST_MUL_A: begin
        prod_r <= -mul;
        acc_r  <= '0;
      end
      ST_MUL_B: begin
        prod_r <= mul;
        acc_r  <= 49'(prod_r);
      end
      ST_SUM:   nx_r[idx_r] <= sat;
      default: ;
    endcase
    if (state_r == ST_DIV && drsp.done) quot_r <= drsp.quotient;
    if (state_r == ST_OUT && (!out_valid_r || out_ch.ready)) out_data_r <= y_r;
    if (state_r == ST_LIMIT) y_r <= lim;
    if (state_r == ST_QUANT) y_r <= qsat;
  end

endmodule
`default_nettype wire
